@@ rtl/core/frnf_pkg.sv @@
`default_nettype none

package frnf_pkg;

    localparam int RADIUS_W = 16;
    localparam int MISS_W   = 16;
    localparam int MUL_W    = 16;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int ROOT_W   = 16;
    localparam int REM_W    = ROOT_W + 3;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET     = 16'd2560;
    localparam logic [MISS_W-1:0]   MISS_LIMIT_RESET = 16'd1500;
    localparam logic [MISS_W-1:0]   MISS_MAX         = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT = 1'b1;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_CAND  = 1'b1;

    localparam logic [1:0] SEL_DX  = 2'd0;
    localparam logic [1:0] SEL_DY  = 2'd1;
    localparam logic [1:0] SEL_DZ  = 2'd2;
    localparam logic [1:0] SEL_RAD = 2'd3;

    localparam logic [STEP_W-1:0] SQRT_LAST = 4'd15;

    typedef struct packed {
        logic       load_query;
        logic       load_cand;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       decide;
        logic       sqrt_step;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic stopped;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/frnf_ctrl.sv @@
`default_nettype none

module frnf_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    input  wire                  kind,
    output logic                 item_ready,
    output frnf_pkg::dp_cmd_t    cmd,
    input  frnf_pkg::dp_status_t status
);
    import frnf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SQRT   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        item_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                    end
                    else if (!status.stopped)
                    begin
                        cmd.load_cand = 1'b1;
                        step_next     = '0;
                        state_next    = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = step_reg[1:0];
                if (step_reg[1:0] == SEL_RAD)
                begin
                    step_next  = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                step_next  = '0;
                state_next = status.hit ? S_SQRT : S_IDLE;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/frnf_dp.sv @@
`default_nettype none

module frnf_dp #(
    parameter int COORD_BITS       = 24,
    parameter int QUERY_INDEX_BITS = 20,
    parameter int POINT_INDEX_BITS = 24
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write,
    input  wire  [frnf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [frnf_pkg::RADIUS_W-1:0]       cfg_data,
    input  wire  signed [COORD_BITS-1:0]        pos_x,
    input  wire  signed [COORD_BITS-1:0]        pos_y,
    input  wire  signed [COORD_BITS-1:0]        pos_z,
    input  frnf_pkg::dp_cmd_t                   cmd,
    output frnf_pkg::dp_status_t                status,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output logic [QUERY_INDEX_BITS-1:0]         query_number,
    output logic [POINT_INDEX_BITS-1:0]         point_number,
    output logic [frnf_pkg::ROOT_W-1:0]         distance
);
    import frnf_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > RADIUS_W) ? DW : RADIUS_W;

    logic [RADIUS_W-1:0] radius_reg;
    logic [MISS_W-1:0]   limit_reg;

    logic [2:0][COORD_BITS-1:0] qpos_reg;
    logic [2:0][COORD_BITS-1:0] ipos;
    logic [2:0][DW-1:0]         diff;
    logic [2:0][DW-1:0]         adiff;
    logic [2:0]                 in_box;
    logic [2:0][MUL_W-1:0]      op_reg;
    logic                       in_range_reg;

    logic [QUERY_INDEX_BITS-1:0] query_cnt_reg;
    logic [POINT_INDEX_BITS-1:0] point_cnt_reg;
    logic                        seen_reg;
    logic [MISS_W-1:0]           miss_reg;
    logic                        stopped_reg;
    logic [MISS_W-1:0]           miss_inc;

    logic [MUL_W-1:0]  mul_op;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] rsq_reg;
    logic              hit;

    logic [PROD_W-1:0] sq_val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    logic [QUERY_INDEX_BITS-1:0] res_query_reg;
    logic [POINT_INDEX_BITS-1:0] res_point_reg;

    assign ipos = {pos_z, pos_y, pos_x};

    // per-axis absolute difference and radius box check
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]   = DW'($signed(qpos_reg[i])) - DW'($signed(ipos[i]));
            adiff[i]  = diff[i][DW-1] ? (~diff[i] + 1'b1) : diff[i];
            in_box[i] = (CW'(adiff[i]) <= CW'(radius_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            limit_reg  <= MISS_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIUS:     radius_reg <= cfg_data;
                REG_MISS_LIMIT: limit_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // shared squarer
    always_comb
    begin
        unique case (cmd.mul_sel)
            SEL_DX:  mul_op = op_reg[0];
            SEL_DY:  mul_op = op_reg[1];
            SEL_DZ:  mul_op = op_reg[2];
            SEL_RAD: mul_op = radius_reg;
            default: mul_op = radius_reg;
        endcase
        prod = mul_op * mul_op;
    end

    assign hit      = in_range_reg && (sum_reg <= SUM_W'(rsq_reg));
    assign miss_inc = (miss_reg == MISS_MAX) ? miss_reg : miss_reg + 1'b1;

    // one root bit per step
    assign rem_sh = {rem_reg[REM_W-3:0], sq_val_reg[PROD_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg      <= '0;
            query_cnt_reg <= '1;
            point_cnt_reg <= '0;
            seen_reg      <= 1'b0;
            miss_reg      <= '0;
            stopped_reg   <= 1'b0;
            in_range_reg  <= 1'b0;
        end
        else if (cmd.load_query)
        begin
            qpos_reg      <= ipos;
            query_cnt_reg <= query_cnt_reg + 1'b1;
            point_cnt_reg <= '0;
            seen_reg      <= 1'b0;
            miss_reg      <= '0;
            stopped_reg   <= 1'b0;
        end
        else if (cmd.load_cand)
        begin
            in_range_reg <= &in_box;
        end
        else if (cmd.decide)
        begin
            if (hit)
            begin
                miss_reg      <= '0;
                seen_reg      <= 1'b1;
                point_cnt_reg <= point_cnt_reg + 1'b1;
            end
            else
            begin
                miss_reg <= miss_inc;
                if (seen_reg && (miss_inc > limit_reg))
                begin
                    stopped_reg <= 1'b1;
                end
                else
                begin
                    point_cnt_reg <= point_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cand)
        begin
            for (int i = 0; i < 3; i++)
            begin
                op_reg[i] <= MUL_W'(CW'(adiff[i]));
            end
            sum_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (cmd.mul_sel == SEL_RAD)
            begin
                rsq_reg <= prod;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(prod);
            end
        end
        if (cmd.decide)
        begin
            sq_val_reg    <= sum_reg[PROD_W-1:0];
            rem_reg       <= '0;
            root_reg      <= '0;
            res_query_reg <= query_cnt_reg;
            res_point_reg <= point_cnt_reg;
        end
        else if (cmd.sqrt_step)
        begin
            sq_val_reg <= {sq_val_reg[PROD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            query_number <= res_query_reg;
            point_number <= res_point_reg;
            distance     <= root_reg;
        end
    end

    assign status.stopped  = stopped_reg;
    assign status.hit      = hit;
    assign status.out_free = !result_valid || result_ready;

    a_stop_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> seen_reg)
        else $error("scan stopped without a hit");

    a_hit_clears_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && hit) |=> (miss_reg == '0 && seen_reg))
        else $error("hit did not clear miss count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid || result_ready))
        else $error("result word overwritten");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && !cmd.load_query) |=> stopped_reg)
        else $error("stopped scan resumed without a query");

endmodule

`default_nettype wire

@@ rtl/core/fixed_radius_neighbor_filter.sv @@
`default_nettype none

// Fixed-radius neighbour filter: a kind 0 word loads a query point and starts a new scan, a
// kind 1 word is a candidate compared with it; a candidate within radius gives one result word
// with query number, candidate number and floored distance. One item is in work at a time.
// A query word, or a candidate of a stopped scan, is done in the accept step alone; a candidate
// that misses takes accept, four passes through the shared 16x16 squarer for the three axes
// and the radius, and compare; a hit adds the one-bit-a-cycle square root and the load of the
// result register. The result register lets the next item be accepted while a result still
// waits to be taken; a further hit then holds in its last cycle until that result is taken.
module fixed_radius_neighbor_filter #(
    parameter int COORD_BITS       = 24,
    parameter int QUERY_INDEX_BITS = 20,
    parameter int POINT_INDEX_BITS = 24
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_write,
    input  wire  [frnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [frnf_pkg::RADIUS_W-1:0]   cfg_data,
    input  wire                             item_valid,
    output logic                            item_ready,
    input  wire                             kind,
    input  wire  signed [COORD_BITS-1:0]    pos_x,
    input  wire  signed [COORD_BITS-1:0]    pos_y,
    input  wire  signed [COORD_BITS-1:0]    pos_z,
    output logic                            result_valid,
    input  wire                             result_ready,
    output logic [QUERY_INDEX_BITS-1:0]     query_number,
    output logic [POINT_INDEX_BITS-1:0]     point_number,
    output logic [frnf_pkg::ROOT_W-1:0]     distance
);
    import frnf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    frnf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    frnf_dp #(
        .COORD_BITS       (COORD_BITS),
        .QUERY_INDEX_BITS (QUERY_INDEX_BITS),
        .POINT_INDEX_BITS (POINT_INDEX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .query_number (query_number),
        .point_number (point_number),
        .distance     (distance)
    );

endmodule

`default_nettype wire

@@ test/tb_fixed_radius_neighbor_filter.sv @@
`default_nettype none

module tb_fixed_radius_neighbor_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import frnf_pkg::*;

    localparam int COORD_W     = 24;
    localparam int QIDX_W      = 20;
    localparam int PIDX_W      = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_word_t;

    typedef struct packed {
        logic [QIDX_W-1:0]   query_num;
        logic [PIDX_W-1:0]   point_num;
        logic [ROOT_W-1:0]   dist_val;
    } hit_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [RADIUS_W-1:0]        cfg_data = '0;
    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic                       kind = 1'b0;
    logic signed [COORD_W-1:0]  pos_x = '0;
    logic signed [COORD_W-1:0]  pos_y = '0;
    logic signed [COORD_W-1:0]  pos_z = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [QIDX_W-1:0]          query_number;
    logic [PIDX_W-1:0]          point_number;
    logic [ROOT_W-1:0]          distance;

    point_word_t point_words[$];
    hit_word_t   near_hits[$];

    logic steady = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   errors = 0;
    int   quiet_cycles = 0;
    int   queued_words = 0;

    // filter state as the block should hold it
    logic signed [COORD_W-1:0] q_x = '0;
    logic signed [COORD_W-1:0] q_y = '0;
    logic signed [COORD_W-1:0] q_z = '0;
    logic [QIDX_W-1:0]         scan_query = '1;
    logic [PIDX_W-1:0]         scan_point = '0;
    logic                      scan_hit = 1'b0;
    logic [MISS_W-1:0]         scan_misses = '0;
    logic                      scan_halted = 1'b0;
    logic [RADIUS_W-1:0]       cfg_radius = RADIUS_RESET;
    logic [MISS_W-1:0]         cfg_miss_limit = MISS_LIMIT_RESET;

    fixed_radius_neighbor_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .query_number (query_number),
        .point_number (point_number),
        .distance     (distance)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint abs_gap(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [ROOT_W-1:0] root_floor(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            trial = root | (longint'(1) << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    task automatic predict_neighbour(input logic k, input logic signed [COORD_W-1:0] px,
                                     input logic signed [COORD_W-1:0] py,
                                     input logic signed [COORD_W-1:0] pz);
        longint    ax;
        longint    ay;
        longint    az;
        longint    r;
        longint    sum;
        logic      hit;
        hit_word_t h;
        if (k == KIND_QUERY)
        begin
            q_x = px;
            q_y = py;
            q_z = pz;
            scan_query = scan_query + 1'b1;
            scan_point = '0;
            scan_hit = 1'b0;
            scan_misses = '0;
            scan_halted = 1'b0;
        end
        else if (!scan_halted)
        begin
            r = cfg_radius;
            ax = abs_gap(q_x, px);
            ay = abs_gap(q_y, py);
            az = abs_gap(q_z, pz);
            hit = 1'b0;
            sum = 0;
            if (ax <= r && ay <= r && az <= r)
            begin
                sum = ax * ax + ay * ay + az * az;
                hit = (sum <= r * r);
            end
            if (hit)
            begin
                h.query_num = scan_query;
                h.point_num = scan_point;
                h.dist_val = root_floor(sum);
                near_hits.push_back(h);
                scan_misses = '0;
                scan_hit = 1'b1;
                scan_point = scan_point + 1'b1;
            end
            else
            begin
                if (scan_misses != MISS_MAX)
                    scan_misses = scan_misses + 1'b1;
                if (scan_hit && scan_misses > cfg_miss_limit)
                    scan_halted = 1'b1;
                else
                    scan_point = scan_point + 1'b1;
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        point_word_t w;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            kind <= 1'b0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (point_words.size() != 0 && (steady || $urandom_range(99) >= 16))
            begin
                w = point_words.pop_front();
                item_valid <= 1'b1;
                kind <= w.kind;
                pos_x <= w.x;
                pos_y <= w.y;
                pos_z <= w.z;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= steady || ($urandom_range(99) >= 16);
    end

    always @(posedge clk)
    begin : check_words
        hit_word_t e;
        logic      progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (result_valid && result_ready)
            begin
                progress = 1'b1;
                if (near_hits.size() == 0)
                begin
                    $display("%0t unexpected word: query %0h point %0h distance %0h",
                             $time, query_number, point_number, distance);
                    errors++;
                end
                else
                begin
                    e = near_hits.pop_front();
                    if (query_number !== e.query_num)
                    begin
                        $display("%0t query_number expected %0h actual %0h",
                                 $time, e.query_num, query_number);
                        errors++;
                    end
                    if (point_number !== e.point_num)
                    begin
                        $display("%0t point_number expected %0h actual %0h",
                                 $time, e.point_num, point_number);
                        errors++;
                    end
                    if (distance !== e.dist_val)
                    begin
                        $display("%0t distance expected %0h actual %0h",
                                 $time, e.dist_val, distance);
                        errors++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                progress = 1'b1;
                predict_neighbour(kind, pos_x, pos_y, pos_z);
            end
            if (progress || (point_words.size() == 0 && !item_valid && near_hits.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, quiet_cycles);
                $display("fixed_radius_neighbor_filter regression: fail");
                $finish;
            end
        end
    end

    task automatic push_point(input logic k, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
        point_word_t w;
        w.kind = k;
        w.x = x;
        w.y = y;
        w.z = z;
        point_words.push_back(w);
        queued_words++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIUS_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_RADIUS)
            cfg_radius = val;
        else
            cfg_miss_limit = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (point_words.size() != 0 || item_valid || near_hits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c,
                                                      input int unsigned span);
        int off;
        off = int'($urandom_range(2 * span)) - int'(span);
        return c + off[COORD_W-1:0];
    endfunction

    task automatic queue_scan(input int unsigned cands, input int unsigned rad);
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        logic [COORD_W-1:0] qz;
        int unsigned        tight;
        int unsigned        loose;
        int unsigned        pick;
        qx = COORD_W'($urandom);
        qy = COORD_W'($urandom);
        qz = COORD_W'($urandom);
        if ($urandom_range(1))
        begin
            qx = {{12{qx[11]}}, qx[11:0]};
            qy = {{12{qy[11]}}, qy[11:0]};
            qz = {{12{qz[11]}}, qz[11:0]};
        end
        push_point(KIND_QUERY, qx, qy, qz);
        tight = rad * 3 / 5;
        loose = rad + rad / 4 + 2;
        repeat (cands)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                push_point(KIND_CAND, qx, qy, qz);
            else if (pick < 55)
                push_point(KIND_CAND, near_coord(qx, tight), near_coord(qy, tight),
                           near_coord(qz, tight));
            else if (pick < 90)
                push_point(KIND_CAND, near_coord(qx, loose), near_coord(qy, loose),
                           near_coord(qz, loose));
            else
                push_point(KIND_CAND, COORD_W'($urandom), COORD_W'($urandom),
                           COORD_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: radius 10.0
        push_point(KIND_CAND, 24'h000000, 24'h000000, 24'h000000);
        push_point(KIND_CAND, 24'd2560, 24'h000000, 24'h000000);
        push_point(KIND_CAND, 24'h000000, -24'sd2561, 24'h000000);
        push_point(KIND_CAND, 24'd1478, -24'sd1478, 24'd1478);
        push_point(KIND_QUERY, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        push_point(KIND_CAND, 24'h800000, 24'h7FFFFF, 24'h800000);
        push_point(KIND_CAND, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        push_point(KIND_CAND, 24'h7FFFFF - 24'd1000, 24'h800000 + 24'd1000,
                   24'h7FFFFF - 24'd2000);
        push_point(KIND_QUERY, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_point(KIND_CAND, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_point(KIND_CAND, 24'h000000, 24'h000000, 24'h000000);
        push_point(KIND_CAND, 24'h555555, 24'hAAAAAA, 24'h555555);
        wait_idle();

        // zero radius, scan stops on the first miss after a hit
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_MISS_LIMIT, 16'd0);
        push_point(KIND_QUERY, 24'h123456, 24'hEDCBA9, 24'h000100);
        push_point(KIND_CAND, 24'h123456, 24'hEDCBA9, 24'h000100);
        push_point(KIND_CAND, 24'h123457, 24'hEDCBA9, 24'h000100);
        push_point(KIND_CAND, 24'h123456, 24'hEDCBA9, 24'h000100);
        push_point(KIND_QUERY, 24'h000000, 24'h000000, 24'h000000);
        push_point(KIND_CAND, 24'h000000, 24'h000000, 24'h000001);
        push_point(KIND_CAND, 24'h000000, 24'h000000, 24'h000000);
        wait_idle();

        // widest radius
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_MISS_LIMIT, 16'hFFFF);
        push_point(KIND_QUERY, 24'h000000, 24'h000000, 24'h000000);
        push_point(KIND_CAND, 24'd65535, 24'h000000, 24'h000000);
        push_point(KIND_CAND, -24'sd65535, 24'hFFFFFF, 24'h000000);
        push_point(KIND_CAND, 24'd37836, 24'd37836, 24'd37836);
        push_point(KIND_CAND, 24'd65536, 24'h000000, 24'h000000);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_RADIUS, RADIUS_W'($urandom_range(512, 4096)));
                    write_reg(REG_MISS_LIMIT, MISS_W'($urandom_range(0, 3)));
                    steady <= 1'b1;
                end
                1:
                begin
                    write_reg(REG_RADIUS, 16'hFFFF);
                    write_reg(REG_MISS_LIMIT, 16'd1);
                    steady <= 1'b0;
                end
                2:
                begin
                    write_reg(REG_RADIUS, 16'd0);
                    write_reg(REG_MISS_LIMIT, 16'd0);
                end
                3:
                begin
                    write_reg(REG_RADIUS, RADIUS_W'($urandom_range(1, 255)));
                    write_reg(REG_MISS_LIMIT, 16'hFFFF);
                end
                4:
                begin
                    write_reg(REG_RADIUS, RADIUS_W'($urandom_range(0, 65535)));
                    write_reg(REG_MISS_LIMIT, MISS_W'($urandom_range(0, 8)));
                end
                default:
                begin
                    write_reg(REG_RADIUS, RADIUS_RESET);
                    write_reg(REG_MISS_LIMIT, MISS_LIMIT_RESET);
                end
            endcase
            queued_words = 0;
            while (queued_words < 290)
                queue_scan($urandom_range(1, 24), cfg_radius);
            if (ph == 1)
                hold_go <= 1'b1;
            wait_idle();
        end

        if (errors == 0)
            $display("fixed_radius_neighbor_filter regression: pass");
        else
            $display("fixed_radius_neighbor_filter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
